[design/wftm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftm_pkg
// Shared types, constants and sequencing helpers of the wheel force trend
// monitor.
// ----------------------------------------------------------------------------
package wftm_pkg;

    localparam logic [15:0] MAX_SAMPLES = 16'd65535;
    localparam logic [15:0] LIMIT_RST   = 16'hFFFF;
    localparam logic [29:0] RUL_CAP     = 30'd1000000000;
    localparam logic [6:0]  ITERS_FULL  = 7'd64;
    localparam logic [6:0]  ITERS_SLOPE = 7'd32;

    typedef struct packed {
        logic [15:0] wafer_index;
        logic [15:0] removed_amount;
        logic [15:0] force_sample;
    } t_in;

    typedef struct packed {
        logic [15:0]        sample_count;
        logic [15:0]        latest_force;
        logic [31:0]        total_removed;
        logic signed [31:0] force_slope;
        logic [39:0]        wear_ratio;
        logic               dress_due;
        logic [29:0]        wafers_to_dress;
        logic               sample_dropped;
    } t_out;

    typedef enum logic [4:0] {
        OP_M1        = 5'd0,
        OP_M2        = 5'd1,
        OP_M3        = 5'd2,
        OP_M4        = 5'd3,
        OP_M5        = 5'd4,
        OP_M6        = 5'd5,
        OP_DEN       = 5'd6,
        OP_DIV_SLOPE = 5'd7,
        OP_SLOPE_END = 5'd8,
        OP_M7        = 5'd9,
        OP_T         = 5'd10,
        OP_DIV_ICPT  = 5'd11,
        OP_RISE      = 5'd12,
        OP_DIV_RATIO = 5'd13,
        OP_RATIO_END = 5'd14,
        OP_DIV_RUL   = 5'd15,
        OP_RUL_END   = 5'd16
    } t_op;

    typedef struct packed {
        logic take;
        logic exec;
        logic load_out;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

    function automatic t_op op_next(t_op op);
        t_op r;
        unique case (op)
            OP_M1:        r = OP_M2;
            OP_M2:        r = OP_M3;
            OP_M3:        r = OP_M4;
            OP_M4:        r = OP_M5;
            OP_M5:        r = OP_M6;
            OP_M6:        r = OP_DEN;
            OP_DEN:       r = OP_DIV_SLOPE;
            OP_DIV_SLOPE: r = OP_SLOPE_END;
            OP_SLOPE_END: r = OP_M7;
            OP_M7:        r = OP_T;
            OP_T:         r = OP_DIV_ICPT;
            OP_DIV_ICPT:  r = OP_RISE;
            OP_RISE:      r = OP_DIV_RATIO;
            OP_DIV_RATIO: r = OP_RATIO_END;
            OP_RATIO_END: r = OP_DIV_RUL;
            OP_DIV_RUL:   r = OP_RUL_END;
            default:      r = OP_M1;
        endcase
        return r;
    endfunction

    function automatic logic op_is_div(t_op op);
        return (op == OP_DIV_SLOPE) || (op == OP_DIV_ICPT) ||
               (op == OP_DIV_RATIO) || (op == OP_DIV_RUL);
    endfunction

endpackage

[design/wftm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftm_div
// Restoring divider, one quotient bit per cycle, 64-bit divisor.
// ----------------------------------------------------------------------------
module wftm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rem0,
    input  logic [63:0] i_dvd,
    input  logic [63:0] i_dvs,
    input  logic [6:0]  i_iters,
    output logic        o_busy,
    output logic [63:0] o_quo
);

    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_l;
    logic [63:0] r_dvs;
    logic [64:0] w_sh;
    logic [64:0] w_sub;
    logic        w_ge;

    always_comb begin
        w_sh  = {r_rem, r_l[63]};
        w_ge  = w_sh >= {1'b0, r_dvs};
        w_sub = w_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_iters;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_l   <= i_dvd;
            r_dvs <= i_dvs;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_sub[63:0] : w_sh[63:0];
            r_l   <= {r_l[62:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_l;

endmodule

[design/wftm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftm_dp
// Running sums, shared multiplier and divider, fit and wear arithmetic.
// ----------------------------------------------------------------------------
module wftm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wftm_pkg::t_cmd   i_cmd,
    input  wftm_pkg::t_in    i_in,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    output wftm_pkg::t_sts   o_sts,
    output wftm_pkg::t_out   o_out
);

    logic [15:0]        r_limit;
    logic [15:0]        r_cnt;
    logic [31:0]        r_sx;
    logic [31:0]        r_sy;
    logic [47:0]        r_sxx;
    logic [47:0]        r_sxy;
    logic [31:0]        r_srm;
    logic [15:0]        r_lf;
    logic               r_drop;
    logic [63:0]        r_prod;
    logic [64:0]        r_acc;
    logic signed [65:0] r_num;
    logic [63:0]        r_den;
    logic signed [31:0] r_slope;
    logic signed [65:0] r_t;
    logic signed [66:0] r_rise;
    logic [39:0]        r_ratio;
    logic [29:0]        r_rul;
    wftm_pkg::t_out     r_out;

    logic [31:0]        w_ma;
    logic [31:0]        w_mb;
    logic [31:0]        w_xx;
    logic [31:0]        w_xf;
    logic [32:0]        w_srm;
    logic [31:0]        w_smag;
    logic [63:0]        w_mag;
    logic [79:0]        w_n16;
    logic               w_ovf;
    logic [63:0]        w_tmag;
    logic               w_dress;
    logic [15:0]        w_diff;
    logic               w_rise_big;
    logic               w_div_start;
    logic [63:0]        w_rem0;
    logic [63:0]        w_dvd;
    logic [63:0]        w_dvs;
    logic [6:0]         w_iters;
    logic               w_busy;
    logic [63:0]        w_quo;
    logic signed [66:0] w_icpt;
    logic signed [66:0] w_rise;
    logic signed [65:0] w_sy16;

    always_comb begin
        w_xx       = i_in.wafer_index * i_in.wafer_index;
        w_xf       = i_in.wafer_index * i_in.force_sample;
        w_srm      = {1'b0, r_srm} + {17'b0, i_in.removed_amount};
        w_smag     = r_slope[31] ? 32'(-r_slope) : 32'(r_slope);
        w_mag      = r_num[65] ? 64'(-r_num) : r_num[63:0];
        w_n16      = {w_mag, 16'b0};
        w_ovf      = {16'b0, w_n16[79:32]} >= r_den;
        w_tmag     = r_t[65] ? 64'(-r_t) : r_t[63:0];
        w_dress    = r_lf >= r_limit;
        w_diff     = r_limit - r_lf;
        w_rise_big = (r_rise[66:64] != 3'b0);
        w_sy16     = {18'b0, r_sy, 16'b0};
        w_icpt     = r_t[65] ? -$signed({3'b0, w_quo}) : $signed({3'b0, w_quo});
        w_rise     = $signed({35'b0, r_lf, 16'b0}) - w_icpt;
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            wftm_pkg::OP_M1: begin w_ma = {16'b0, r_cnt}; w_mb = r_sxy[31:0]; end
            wftm_pkg::OP_M2: begin w_ma = {16'b0, r_cnt}; w_mb = {16'b0, r_sxy[47:32]}; end
            wftm_pkg::OP_M3: begin w_ma = r_sx;           w_mb = r_sy; end
            wftm_pkg::OP_M4: begin w_ma = {16'b0, r_cnt}; w_mb = r_sxx[31:0]; end
            wftm_pkg::OP_M5: begin w_ma = {16'b0, r_cnt}; w_mb = {16'b0, r_sxx[47:32]}; end
            wftm_pkg::OP_M6: begin w_ma = r_sx;           w_mb = r_sx; end
            wftm_pkg::OP_M7: begin w_ma = w_smag;         w_mb = r_sx; end
            default: begin end
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_rem0      = '0;
        w_dvd       = '0;
        w_dvs       = '0;
        w_iters     = wftm_pkg::ITERS_FULL;
        unique case (i_cmd.op)
            wftm_pkg::OP_DIV_SLOPE: begin
                w_div_start = i_cmd.exec && (r_den != '0) && !w_ovf;
                w_rem0      = {16'b0, w_n16[79:32]};
                w_dvd       = {w_n16[31:0], 32'b0};
                w_dvs       = r_den;
                w_iters     = wftm_pkg::ITERS_SLOPE;
            end
            wftm_pkg::OP_DIV_ICPT: begin
                w_div_start = i_cmd.exec;
                w_dvd       = w_tmag;
                w_dvs       = {48'b0, r_cnt};
            end
            wftm_pkg::OP_DIV_RATIO: begin
                w_div_start = i_cmd.exec && !w_rise_big;
                w_dvd       = {8'b0, r_srm, 24'b0};
                w_dvs       = r_rise[63:0];
            end
            wftm_pkg::OP_DIV_RUL: begin
                w_div_start = i_cmd.exec && !w_dress && (r_slope > 32'sd0);
                w_dvd       = {32'b0, w_diff, 16'b0};
                w_dvs       = {32'b0, r_slope};
            end
            default: begin end
        endcase
    end

    wftm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem0  (w_rem0),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .i_iters (w_iters),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= wftm_pkg::LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
            r_srm <= '0;
            r_lf  <= '0;
        end else if (i_cmd.take && (r_cnt < wftm_pkg::MAX_SAMPLES)) begin
            r_cnt <= r_cnt + 16'd1;
            r_sx  <= r_sx + {16'b0, i_in.wafer_index};
            r_sy  <= r_sy + {16'b0, i_in.force_sample};
            r_sxx <= r_sxx + {16'b0, w_xx};
            r_sxy <= r_sxy + {16'b0, w_xf};
            r_srm <= w_srm[32] ? 32'hFFFF_FFFF : w_srm[31:0];
            r_lf  <= i_in.force_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_drop <= (r_cnt >= wftm_pkg::MAX_SAMPLES);
        end
        if (i_cmd.exec) begin
            r_prod <= 64'(w_ma) * 64'(w_mb);
            unique case (i_cmd.op)
                wftm_pkg::OP_M2, wftm_pkg::OP_M5: r_acc <= {1'b0, r_prod};
                wftm_pkg::OP_M3, wftm_pkg::OP_M6: r_acc <= r_acc + {r_prod[32:0], 32'b0};
                wftm_pkg::OP_M4: r_num <= $signed({1'b0, r_acc}) - $signed({2'b0, r_prod});
                wftm_pkg::OP_DEN: r_den <= r_acc[63:0] - r_prod;
                wftm_pkg::OP_SLOPE_END: begin
                    if (r_den == '0) begin
                        r_slope <= '0;
                    end else if (r_num[65]) begin
                        r_slope <= (w_ovf || (w_quo[31:0] > 32'h8000_0000)) ?
                                   32'sh8000_0000 : -$signed(w_quo[31:0]);
                    end else begin
                        r_slope <= (w_ovf || w_quo[31]) ? 32'sh7FFF_FFFF
                                                        : $signed(w_quo[31:0]);
                    end
                end
                wftm_pkg::OP_T: begin
                    r_t <= r_slope[31] ? w_sy16 + $signed({2'b0, r_prod})
                                       : w_sy16 - $signed({2'b0, r_prod});
                end
                wftm_pkg::OP_RISE: begin
                    r_rise <= (w_rise[66] || (w_rise == '0)) ? 67'sd1 : w_rise;
                end
                wftm_pkg::OP_RATIO_END: begin
                    if (w_rise_big) begin
                        r_ratio <= '0;
                    end else begin
                        r_ratio <= (w_quo[63:40] != '0) ? 40'hFF_FFFF_FFFF : w_quo[39:0];
                    end
                end
                wftm_pkg::OP_RUL_END: begin
                    if (w_dress) begin
                        r_rul <= '0;
                    end else if (r_slope <= 32'sd0) begin
                        r_rul <= wftm_pkg::RUL_CAP;
                    end else begin
                        r_rul <= (w_quo > {34'b0, wftm_pkg::RUL_CAP}) ?
                                 wftm_pkg::RUL_CAP : w_quo[29:0];
                    end
                end
                default: begin end
            endcase
        end
        if (i_cmd.load_out) begin
            r_out.sample_count    <= r_cnt;
            r_out.latest_force    <= r_lf;
            r_out.total_removed   <= r_srm;
            r_out.force_slope     <= r_slope;
            r_out.wear_ratio      <= r_ratio;
            r_out.dress_due       <= w_dress;
            r_out.wafers_to_dress <= r_rul;
            r_out.sample_dropped  <= r_drop;
        end
    end

    assign o_sts.div_busy = w_busy;
    assign o_out          = r_out;

endmodule

[design/wftm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftm_ctrl
// Sequencer: steps the datapath through the fit, waits on divisions and
// hands the finished beat to the output register.
// ----------------------------------------------------------------------------
module wftm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  wftm_pkg::t_sts i_sts,
    output wftm_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    wftm_pkg::t_op r_op;
    wftm_pkg::t_op n_op;
    logic          r_out_valid;
    logic          w_free;

    assign w_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        o_cmd.take     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.op       = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_op       = wftm_pkg::OP_M1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (wftm_pkg::op_is_div(r_op)) begin
                    n_state = S_WAIT;
                end else if (r_op == wftm_pkg::OP_RUL_END) begin
                    n_state = S_DONE;
                end else begin
                    n_op = wftm_pkg::op_next(r_op);
                end
            end
            S_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_op    = wftm_pkg::op_next(r_op);
                    n_state = S_EXEC;
                end
            end
            S_DONE: begin
                if (w_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= wftm_pkg::OP_M1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/wheel_force_trend_monitor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_force_trend_monitor_core
// Wheel force trend monitor: least-squares force slope, wear ratio and
// wafers left to dress, from running sums over accepted samples.
// ----------------------------------------------------------------------------
// One sample at a time: each beat steps from acceptance through the fit on
// the shared 32x32 multiplier and the shared restoring divider, which divides
// for the slope, intercept, wear ratio and wafers to dress; a division that
// is not needed is not started. The input stalls until the result is loaded;
// the finished beat sits in an output register, so the next sample is taken
// while it waits. Samples past capacity are dropped and flagged; the result
// then reflects the unchanged sums.
module wheel_force_trend_monitor_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  wftm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output wftm_pkg::t_out o_out_data,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data
);

    wftm_pkg::t_cmd w_cmd;
    wftm_pkg::t_sts w_sts;

    wftm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    wftm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in          (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_sts         (w_sts),
        .o_out         (o_out_data)
    );

    a_take_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous sample still in work");

    a_rul_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.wafers_to_dress <= wftm_pkg::RUL_CAP))
        else $error("wafers to dress above cap");

    a_dress_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.dress_due) |-> (o_out_data.wafers_to_dress == '0))
        else $error("dress flagged with wafers remaining");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sample_dropped) |->
        (o_out_data.sample_count == wftm_pkg::MAX_SAMPLES))
        else $error("sample dropped below capacity");

endmodule

[dv/wheel_force_trend_monitor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_force_trend_monitor_core_tb
// Drives wafer samples into the trend monitor with random gaps and output
// stalls, predicts each result from running sums kept in the bench, and
// compares every field of every result beat in order.
// ----------------------------------------------------------------------------
module wheel_force_trend_monitor_core_tb;

    localparam int LATENCY = 300;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    wftm_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall;
    wftm_pkg::t_out out_data;
    logic           cfg_wr_en;
    logic [15:0]    cfg_wr_data;

    wftm_pkg::t_in  pending_samples[$];
    wftm_pkg::t_out expected_results[$];
    int   error_count;
    int   in_wait;
    int   out_wait;
    int   out_next_wait;
    bit   stall_free;
    bit   gap_free;

    logic [15:0] limit_reg;
    logic [15:0] n_acc;
    logic [31:0] sx_acc;
    logic [31:0] sy_acc;
    logic [47:0] sxx_acc;
    logic [47:0] sxy_acc;
    logic [31:0] removed_acc;
    logic [15:0] last_f;

    wheel_force_trend_monitor_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wftm_pkg::t_out predict_trend(wftm_pkg::t_in smp);
        wftm_pkg::t_out r;
        logic signed [127:0] num, den, t, icpt, rise, q;
        logic [127:0] mag, ratio, rul;
        logic signed [63:0] s;
        r = '0;
        if (n_acc == wftm_pkg::MAX_SAMPLES) begin
            r.sample_dropped = 1'b1;
        end else begin
            n_acc = n_acc + 16'd1;
            sx_acc = sx_acc + {16'd0, smp.wafer_index};
            sy_acc = sy_acc + {16'd0, smp.force_sample};
            sxx_acc = sxx_acc + 48'(smp.wafer_index) * 48'(smp.wafer_index);
            sxy_acc = sxy_acc + 48'(smp.wafer_index) * 48'(smp.force_sample);
            removed_acc = (33'(removed_acc) + 33'(smp.removed_amount) > 33'hFFFFFFFF) ?
                          32'hFFFFFFFF : removed_acc + {16'd0, smp.removed_amount};
            last_f = smp.force_sample;
        end
        if (n_acc == 0) return r;
        num = $signed({64'd0, 48'd0, n_acc}) * $signed({80'd0, sxy_acc})
            - $signed({96'd0, sx_acc}) * $signed({96'd0, sy_acc});
        den = $signed({112'd0, n_acc}) * $signed({80'd0, sxx_acc})
            - $signed({96'd0, sx_acc}) * $signed({96'd0, sx_acc});
        s = 0;
        if (den != 0) begin
            mag = num < 0 ? -num : num;
            q = (mag << 16) / den;
            if (num < 0) s = q > 128'h80000000 ? -64'sd2147483648 : 64'(-q);
            else s = q > 128'h7FFFFFFF ? 64'sd2147483647 : 64'(q);
        end
        t = ($signed({96'd0, sy_acc}) <<< 16) - 128'(s) * $signed({96'd0, sx_acc});
        mag = t < 0 ? -t : t;
        icpt = mag / {112'd0, n_acc};
        if (t < 0) icpt = -icpt;
        rise = $signed({112'd0, last_f}) * 128'sd65536 - icpt;
        if (rise <= 0) rise = 128'sd1;
        if (rise > $signed(128'hFFFFFFFFFFFFFFFF)) begin
            ratio = '0;
        end else begin
            ratio = ({96'd0, removed_acc} << 24) / rise;
            if (ratio > 128'hFFFFFFFFFF) ratio = 128'hFFFFFFFFFF;
        end
        r.sample_count = n_acc;
        r.latest_force = last_f;
        r.total_removed = removed_acc;
        r.force_slope = s[31:0];
        r.wear_ratio = ratio[39:0];
        r.dress_due = last_f >= limit_reg;
        if (r.dress_due) begin
            rul = '0;
        end else if (s > 0) begin
            rul = ({112'd0, limit_reg - last_f} << 16) / s;
            if (rul > 128'(wftm_pkg::RUL_CAP)) rul = 128'(wftm_pkg::RUL_CAP);
        end else begin
            rul = 128'(wftm_pkg::RUL_CAP);
        end
        r.wafers_to_dress = rul[29:0];
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_wait  <= 0;
        end else if (in_valid && !in_stall) begin
            expected_results.insert(expected_results.size(), predict_trend(in_data));
            in_valid <= 1'b0;
            in_wait  <= gap_free ? 0 : int'($urandom_range(0, 15));
        end else if (!in_valid) begin
            if (in_wait > 0) begin
                in_wait <= in_wait - 1;
            end else if (pending_samples.size() > 0) begin
                in_data  <= pending_samples.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // monitor: hold each result beat for its drawn wait, then take it
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_wait  <= 0;
        end else begin
            out_next_wait = out_wait;
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count = error_count + 1;
                end else begin
                    wftm_pkg::t_out e;
                    e = expected_results.pop_front();
                    if (out_data.sample_count !== e.sample_count) begin
                        $error("sample_count exp %0d got %0d", e.sample_count,
                               out_data.sample_count);
                        error_count = error_count + 1;
                    end
                    if (out_data.latest_force !== e.latest_force) begin
                        $error("latest_force exp %0d got %0d", e.latest_force,
                               out_data.latest_force);
                        error_count = error_count + 1;
                    end
                    if (out_data.total_removed !== e.total_removed) begin
                        $error("total_removed exp %0d got %0d", e.total_removed,
                               out_data.total_removed);
                        error_count = error_count + 1;
                    end
                    if (out_data.force_slope !== e.force_slope) begin
                        $error("force_slope exp %0d got %0d", e.force_slope,
                               out_data.force_slope);
                        error_count = error_count + 1;
                    end
                    if (out_data.wear_ratio !== e.wear_ratio) begin
                        $error("wear_ratio exp %0d got %0d", e.wear_ratio,
                               out_data.wear_ratio);
                        error_count = error_count + 1;
                    end
                    if (out_data.dress_due !== e.dress_due) begin
                        $error("dress_due exp %0d got %0d", e.dress_due,
                               out_data.dress_due);
                        error_count = error_count + 1;
                    end
                    if (out_data.wafers_to_dress !== e.wafers_to_dress) begin
                        $error("wafers_to_dress exp %0d got %0d", e.wafers_to_dress,
                               out_data.wafers_to_dress);
                        error_count = error_count + 1;
                    end
                    if (out_data.sample_dropped !== e.sample_dropped) begin
                        $error("sample_dropped exp %0d got %0d", e.sample_dropped,
                               out_data.sample_dropped);
                        error_count = error_count + 1;
                    end
                end
                out_next_wait = stall_free ? 0 : int'($urandom_range(0, 15));
            end else if (out_valid && out_wait > 0) begin
                out_next_wait = out_wait - 1;
            end
            out_wait  <= out_next_wait;
            out_stall <= (out_next_wait != 0);
        end
    end

    task automatic write_limit(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        limit_reg = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_results();
        do @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [15:0] x, input logic [15:0] rm,
                                input logic [15:0] f);
        wftm_pkg::t_in s;
        s.wafer_index    = x;
        s.removed_amount = rm;
        s.force_sample   = f;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // wear run: force rising at a random slope (possibly flat) with noise
    task automatic queue_wear_run(input int len);
        logic [15:0] x0, f0, slope;
        x0    = 16'($urandom);
        f0    = 16'($urandom_range(0, 40000));
        slope = 16'($urandom_range(0, 64));
        for (int k = 0; k < len; k++)
            queue_sample(16'(x0 + k), 16'($urandom),
                         16'(f0 + slope * k + $urandom_range(0, 31)));
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        error_count = 0;
        stall_free  = 1'b0;
        gap_free    = 1'b0;
        limit_reg   = wftm_pkg::LIMIT_RST;
        n_acc = '0; sx_acc = '0; sy_acc = '0; sxx_acc = '0; sxy_acc = '0;
        removed_acc = '0; last_f = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single sample, equal indices, extremes, falling and rising
        queue_sample(16'd5, 16'd0, 16'd0);
        queue_sample(16'd5, 16'hFFFF, 16'hFFFF);
        queue_sample(16'hFFFF, 16'hFFFF, 16'd0);
        queue_sample(16'd0, 16'hFFFF, 16'hFFFF);
        queue_sample(16'd1, 16'd16, 16'd100);
        queue_sample(16'd2, 16'd16, 16'd200);
        queue_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        queue_sample(16'h5555, 16'hAAAA, 16'h5555);
        drain_results();
        write_limit(16'd0);
        queue_sample(16'd3, 16'd1, 16'd10);
        queue_sample(16'd4, 16'd1, 16'd0);
        drain_results();
        write_limit(16'd300);
        for (int k = 0; k < 6; k++) queue_sample(16'(10 + k), 16'd20, 16'(100 + 30 * k));
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            stall_free = (ph == 2);
            gap_free   = (ph == 3);
            unique case (ph)
                0: write_limit(16'hFFFF);
                1: write_limit(16'd1);
                default: write_limit(16'($urandom));
            endcase
            for (int r = 0; r < 5; r++) queue_wear_run($urandom_range(10, 30));
            for (int k = 0; k < 22; k++)
                queue_sample(16'($urandom), 16'($urandom), 16'($urandom));
            drain_results();
        end

        wait (expected_results.size() == 0);
        repeat (LATENCY) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("wheel_force_trend_monitor_core_tb passed");
        end else begin
            $display("wheel_force_trend_monitor_core_tb failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("wheel_force_trend_monitor_core_tb failed");
        $finish;
    end

endmodule
